// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the branch predictor.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold at every rising edge outside of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// ===== rtl/lhbp_pkg.sv =====
// Types and constants of the local history branch predictor.
// Depends on nothing; used by local_history_branch_predictor.
package lhbp_pkg;

    localparam int ADDR_W      = 32;
    localparam int HIST_W      = 3;
    localparam int CTR_W       = 3;
    localparam int NUM_CTR     = 1 << HIST_W;
    localparam int OUT_IDX_W   = 4;
    localparam int IDX_LSB     = 2;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CTR_W-1:0] CTR_MAX = 3'd7;
    localparam logic [CTR_W-1:0] CTR_MIN = 3'd0;

    // One table row: the local history and the counters it selects.
    typedef struct packed {
        logic [HIST_W-1:0]              hist;
        logic [NUM_CTR-1:0][CTR_W-1:0]  ctr;
    } row_t;

    // Saturating move of a counter toward the outcome.
    function automatic logic [CTR_W-1:0] ctr_update(input logic [CTR_W-1:0] ctr,
                                                    input logic taken);
        logic [CTR_W-1:0] res;
        res = ctr;
        if (taken)
        begin
            if (ctr != CTR_MAX)
            begin
                res = ctr + CTR_W'(1);
            end
        end
        else
        begin
            if (ctr != CTR_MIN)
            begin
                res = ctr - CTR_W'(1);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/local_history_branch_predictor.sv =====
// Two-level local history branch predictor: a row table of history and counters.
// Depends on lhbp_pkg and assert_macros.svh.
// A request is registered in the first stage, then in the result register; throughput: 1
// request per cycle while out_stall is low, set by a read-modify-write of one table row with
// write-through forwarding. Reset: asynchronous; afterwards a clearing pass zeroes all
// 2**floor(log2(ENTRIES)) table rows, and no request is accepted until it ends.
`include "assert_macros.svh"

module local_history_branch_predictor #(
    parameter int ENTRIES = lhbp_pkg::ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lhbp_pkg::ADDR_W-1:0]    branch_addr,
    input  logic                           outcome_taken,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           predict_taken,
    output logic                           mispredict,
    output logic [lhbp_pkg::OUT_IDX_W-1:0] entry_index,
    output logic [lhbp_pkg::CTR_W-1:0]     counter_before
);
    import lhbp_pkg::*;

    // Index bits are floor(log2(ENTRIES)); at least one bit is kept for the storage.
    localparam int K     = $clog2(ENTRIES + 1) - 1;
    localparam int IW    = (K < 1) ? 1 : K;
    localparam int ROWS  = 1 << K;
    localparam int EXT_W = IW + OUT_IDX_W;

    row_t               mem [ROWS];

    logic               clr_busy_reg;
    logic [IW-1:0]      clr_idx_reg;

    logic               s1_valid_reg;
    logic [IW-1:0]      s1_idx_reg;
    logic               s1_taken_reg;
    row_t               row_reg;

    logic               out_valid_reg;
    logic               pred_reg;
    logic               miss_reg;
    logic [OUT_IDX_W-1:0] index_reg;
    logic [CTR_W-1:0]   ctr_reg;

    logic               out_free;
    logic               s1_adv;
    logic               in_acc;
    logic [IW-1:0]      idx_in;
    logic [HIST_W-1:0]  hist_cur;
    logic [CTR_W-1:0]   ctr_cur;
    logic               pred_cur;
    row_t               row_next;
    logic [EXT_W-1:0]   idx_ext;

    // Handshake: the result register frees the first stage, which frees the input.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = clr_busy_reg || (s1_valid_reg && !out_free);
    assign in_acc   = in_valid && !in_stall;

    // Entry index from the address bits above the byte offset.
    assign idx_in = (K == 0) ? '0 : branch_addr[IDX_LSB +: IW];

    // Prediction and row update for the item in the first stage.
    always_comb
    begin
        hist_cur = row_reg.hist;
        ctr_cur  = row_reg.ctr[hist_cur];
        pred_cur = ctr_cur[CTR_W-1];
        row_next = row_reg;
        row_next.ctr[hist_cur] = ctr_update(ctr_cur, s1_taken_reg);
        row_next.hist = {hist_cur[HIST_W-2:0], s1_taken_reg};
        idx_ext = EXT_W'(s1_idx_reg);
    end

    // Clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == IW'(ROWS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + IW'(1);
            end
        end
    end

    // Table writes: zeros during the clearing pass, the updated row otherwise.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (s1_adv)
        begin
            mem[s1_idx_reg] <= row_next;
        end
    end

    // Row read on accept, forwarding the row written at the same edge.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_idx_reg   <= idx_in;
            s1_taken_reg <= outcome_taken;
            if (s1_adv && (s1_idx_reg == idx_in))
            begin
                row_reg <= row_next;
            end
            else
            begin
                row_reg <= mem[idx_in];
            end
        end
    end

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pred_reg  <= pred_cur;
            miss_reg  <= pred_cur ^ s1_taken_reg;
            index_reg <= idx_ext[OUT_IDX_W-1:0];
            ctr_reg   <= ctr_cur;
        end
    end

    assign out_valid      = out_valid_reg;
    assign predict_taken  = pred_reg;
    assign mispredict     = miss_reg;
    assign entry_index    = index_reg;
    assign counter_before = ctr_reg;

    // The clearing pass and pipeline traffic never overlap.
    `ASSERT_ALWAYS(a_clear_idle, !(clr_busy_reg && s1_valid_reg), "request in flight during clear")
    `ASSERT_IMPL(a_clear_stall, clr_busy_reg, in_stall, "input open during clearing pass")
    // The prediction is the top bit of the counter that produced it.
    `ASSERT_IMPL(a_pred_ctr, out_valid_reg, predict_taken == counter_before[CTR_W-1],
        "prediction disagrees with counter")
    // A new result only follows a request that sat in the first stage.
    `ASSERT_IMPL(a_out_src, $rose(out_valid_reg), $past(s1_valid_reg), "result without request")

endmodule
